>>> sv/afa_pkg.sv
// Shared types, sizes and codes for the aligned first-fit allocator.
// Used by afa_rem and aligned_first_fit_allocator; depends on nothing.
package afa_pkg;

   localparam int ADDR_W     = 32;
   localparam int ALIGN_W    = 17;
   localparam int FREE_DEPTH = 64;
   localparam int USED_DEPTH = 64;
   localparam int FIDX_W     = $clog2(FREE_DEPTH);
   localparam int UIDX_W     = $clog2(USED_DEPTH);
   localparam int FCNT_W     = $clog2(FREE_DEPTH + 1);
   localparam int UCNT_W     = $clog2(USED_DEPTH + 1);
   localparam int SCAN_W     = (FCNT_W > UCNT_W) ? FCNT_W : UCNT_W;
   localparam int REM_CNT_W  = $clog2(ADDR_W + 1);

   localparam logic [ADDR_W-1:0] POOL_RESET = ADDR_W'(32'd16777216);

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_REALLOC = 2'd2,
      OP_RSVD    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_NO_SPACE = 3'd1,
      STS_NOT_FND  = 3'd2,
      STS_FULL     = 3'd3,
      STS_BAD      = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_USCAN_RD, S_USCAN_CK,
      S_FSCAN_RD, S_FSCAN_CK, S_FDECIDE,
      S_UMV_RD, S_UMV_WR, S_FEDIT, S_GROW,
      S_ASCAN_RD, S_ASCAN_LD, S_ASCAN_DIV, S_ASCAN_CK,
      S_AEDIT, S_ANEXT,
      S_SU_RD, S_SU_WR, S_INSW, S_SD_RD, S_SD_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic [ADDR_W-1:0]  dividend;
      logic [ALIGN_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic               busy;
      logic [ALIGN_W-1:0] remainder;
   } rem_rsp_type;

endpackage

>>> sv/afa_rem.sv
// Bit-serial restoring remainder unit: offset modulo alignment, one bit a cycle.
// Depends on afa_pkg.
module afa_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  afa_pkg::rem_req_type req,
   output afa_pkg::rem_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic [afa_pkg::REM_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [afa_pkg::ADDR_W-1:0]      quo_ff, quo_in;
   logic [afa_pkg::ALIGN_W-1:0]     rem_ff, rem_in;
   logic [afa_pkg::ALIGN_W-1:0]     div_ff, div_in;
   logic [afa_pkg::ALIGN_W:0]       trial;

   // shift one dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[afa_pkg::ADDR_W-1]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = afa_pkg::REM_CNT_W'(afa_pkg::ADDR_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = afa_pkg::ALIGN_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[afa_pkg::ALIGN_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == afa_pkg::REM_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.remainder = rem_ff;

endmodule

>>> sv/aligned_first_fit_allocator.sv
// Top level: first-fit pool allocator with free/used block tables and a sequencer.
// Depends on afa_pkg and afa_rem.
//
//  channel | ports                        | direction | accept
//  req     | req_valid/stall, op..align   | in        | valid && !stall
//  rsp     | rsp_valid/stall, status..len | out       | valid && !stall
//  csr     | csr_wr_en, csr_wr_data       | in        | wr_en (idle only)
//
// One transaction at a time. Cost is set by the table scans: the used scan, the free
// scan and the alloc scan, which waits on the serial remainder unit for each free entry
// visited, plus an entry-by-entry shift for table insert/remove.
// Reset and a pool_size write seed the free table in S_INIT.
// A result waiting on rsp_stall holds the next one in S_DONE; req_stall stays high until done.
module aligned_first_fit_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [31:0]                   req_offset,
   input  logic [31:0]                   req_size,
   input  logic [16:0]                   req_align,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [31:0]                   rsp_out_offset,
   output logic                          rsp_moved,
   output logic [31:0]                   rsp_copy_from,
   output logic [31:0]                   rsp_copy_length,
   input  logic                          csr_wr_en,
   input  logic [31:0]                   csr_wr_data
);

   localparam int AW = afa_pkg::ADDR_W;
   localparam int LW = afa_pkg::ALIGN_W;
   localparam int SW = afa_pkg::SCAN_W;
   localparam int FW = afa_pkg::FCNT_W;
   localparam int UW = afa_pkg::UCNT_W;

   afa_pkg::state_type  state_ff, state_in, ret_ff, ret_in;
   afa_pkg::op_type     op_ff, op_in;
   afa_pkg::status_type sts_ff, sts_in;

   logic [AW-1:0] pool_ff, pool_in;
   logic [AW-1:0] roff_ff, roff_in, rsize_ff, rsize_in;
   logic [LW-1:0] ralign_ff, ralign_in;
   logic [FW-1:0] fcnt_ff, fcnt_in;
   logic [UW-1:0] ucnt_ff, ucnt_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [afa_pkg::UIDX_W-1:0] u_ff, u_in;
   logic [AW-1:0] ulen_ff, ulen_in;
   logic [FW-1:0] p_ff, p_in;
   logic          mp_ff, mp_in, mn_ff, mn_in, moving_ff, moving_in;
   logic [AW-1:0] prevoff_ff, prevoff_in, prevlen_ff, prevlen_in, nextlen_ff, nextlen_in;
   logic [AW-1:0] aoff_ff, aoff_in, alen_ff, alen_in, atrail_ff, atrail_in;
   logic [LW-1:0] apad_ff, apad_in;
   logic [afa_pkg::FIDX_W-1:0] ai_ff, ai_in;
   logic [FW-1:0] sh_ff, sh_in, tgt_ff, tgt_in;
   afa_pkg::entry_type ins_ff, ins_in;
   logic [AW-1:0] res_ff, res_in;
   logic          mvd_ff, mvd_in;

   logic          rsp_valid_ff, rsp_valid_in;
   afa_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_off_ff, rsp_off_in, rsp_from_ff, rsp_from_in, rsp_len_ff, rsp_len_in;
   logic          rsp_moved_ff, rsp_moved_in;

   // table memories
   afa_pkg::entry_type fmem [afa_pkg::FREE_DEPTH];
   afa_pkg::entry_type umem [afa_pkg::USED_DEPTH];
   afa_pkg::entry_type f_rd_ff, u_rd_ff;
   logic                       f_we, u_we;
   logic [afa_pkg::FIDX_W-1:0] f_wa, f_ra;
   logic [afa_pkg::UIDX_W-1:0] u_wa, u_ra;
   afa_pkg::entry_type f_wd, u_wd;

   afa_pkg::rem_req_type rem_req;
   afa_pkg::rem_rsp_type rem_rsp;

   // decision terms
   logic          accept, req_bad;
   logic [LW-1:0] pad_c;
   logic [AW:0]   need_c;
   logic          fits_c;
   logic [AW-1:0] trail_c;
   logic [1:0]    adds_c, aadds_c;
   logic [FW:0]   fcnt_after_c;
   logic          mp2_c, mn2_c, alloc_fail_c, free_full_c;
   logic          shrink_c, same_c, grow_c;
   logic [AW-1:0] amt_c, newoff_c, tailoff_c;

   afa_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   assign req_stall = (state_ff != afa_pkg::S_IDLE) || csr_wr_en;
   assign accept    = req_valid && !req_stall;
   assign req_bad   = (afa_pkg::op_type'(req_op) == afa_pkg::OP_RSVD) ||
                      ((afa_pkg::op_type'(req_op) == afa_pkg::OP_ALLOC) &&
                       ((req_size == '0) || (req_align == '0)));

   // alloc fit test on the candidate free block
   always_comb begin
      pad_c   = (rem_rsp.remainder == '0) ? '0 : (ralign_ff - rem_rsp.remainder);
      need_c  = {1'b0, rsize_ff} + (AW+1)'(pad_c);
      fits_c  = need_c <= {1'b0, alen_ff};
      trail_c = alen_ff - AW'(pad_c) - rsize_ff;
      adds_c  = 2'((pad_c != '0)) + 2'((trail_c != '0));
      fcnt_after_c = {1'b0, fcnt_ff} - 1'b1 + (FW+1)'(adds_c);
      // neighbors of the old block once the new block has been carved out
      mp2_c = mp_ff && !((FW'(idx_ff) == (p_ff - 1'b1)) && (trail_c == '0));
      mn2_c = mn_ff && !((FW'(idx_ff) == p_ff) && (pad_c == '0));
      alloc_fail_c = (ucnt_ff >= UW'(afa_pkg::USED_DEPTH)) ||
                     (fcnt_after_c > (FW+1)'(afa_pkg::FREE_DEPTH)) ||
                     ((op_ff == afa_pkg::OP_REALLOC) && !mp2_c && !mn2_c &&
                      (fcnt_after_c >= (FW+1)'(afa_pkg::FREE_DEPTH)));
      free_full_c = !mp_ff && !mn_ff && (fcnt_ff >= FW'(afa_pkg::FREE_DEPTH));
      shrink_c = rsize_ff < ulen_ff;
      same_c   = rsize_ff == ulen_ff;
      grow_c   = mn_ff && ({1'b0, rsize_ff} <= ({1'b0, ulen_ff} + {1'b0, nextlen_ff}));
      amt_c    = rsize_ff - ulen_ff;
      aadds_c  = 2'((apad_ff != '0)) + 2'((atrail_ff != '0));
      newoff_c = aoff_ff + AW'(apad_ff);
      tailoff_c = newoff_c + rsize_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         afa_pkg::S_INIT: state_in = afa_pkg::S_IDLE;
         afa_pkg::S_IDLE: begin
            if (csr_wr_en) begin
               state_in = afa_pkg::S_INIT;
            end else if (accept) begin
               if (req_bad) begin
                  state_in = afa_pkg::S_DONE;
               end else if (afa_pkg::op_type'(req_op) == afa_pkg::OP_ALLOC) begin
                  state_in = afa_pkg::S_ASCAN_RD;
               end else begin
                  state_in = afa_pkg::S_USCAN_RD;
               end
            end
         end
         afa_pkg::S_USCAN_RD: state_in = (UW'(idx_ff) >= ucnt_ff) ? afa_pkg::S_DONE
                                                                 : afa_pkg::S_USCAN_CK;
         afa_pkg::S_USCAN_CK: state_in = (u_rd_ff.off == roff_ff) ? afa_pkg::S_FSCAN_RD
                                                                  : afa_pkg::S_USCAN_RD;
         afa_pkg::S_FSCAN_RD: state_in = (FW'(idx_ff) >= fcnt_ff) ? afa_pkg::S_FDECIDE
                                                                 : afa_pkg::S_FSCAN_CK;
         afa_pkg::S_FSCAN_CK: state_in = afa_pkg::S_FSCAN_RD;
         afa_pkg::S_FDECIDE: begin
            priority if (moving_ff) begin
               state_in = afa_pkg::S_FEDIT;
            end else if (op_ff == afa_pkg::OP_FREE) begin
               state_in = free_full_c ? afa_pkg::S_DONE : afa_pkg::S_UMV_RD;
            end else if (shrink_c || same_c) begin
               state_in = afa_pkg::S_DONE;
            end else if (grow_c) begin
               state_in = afa_pkg::S_GROW;
            end else if (ralign_ff == '0) begin
               state_in = afa_pkg::S_DONE;
            end else begin
               state_in = afa_pkg::S_ASCAN_RD;
            end
         end
         afa_pkg::S_UMV_RD: state_in = afa_pkg::S_UMV_WR;
         afa_pkg::S_UMV_WR: state_in = afa_pkg::S_FEDIT;
         afa_pkg::S_FEDIT: begin
            priority if (mp_ff && mn_ff) begin
               state_in = afa_pkg::S_SD_RD;
            end else if (mp_ff || mn_ff) begin
               state_in = afa_pkg::S_DONE;
            end else begin
               state_in = afa_pkg::S_SU_RD;
            end
         end
         afa_pkg::S_GROW: state_in = (amt_c == nextlen_ff) ? afa_pkg::S_SD_RD
                                                           : afa_pkg::S_DONE;
         afa_pkg::S_ASCAN_RD: state_in = (FW'(idx_ff) >= fcnt_ff) ? afa_pkg::S_DONE
                                                                 : afa_pkg::S_ASCAN_LD;
         afa_pkg::S_ASCAN_LD: state_in = afa_pkg::S_ASCAN_DIV;
         afa_pkg::S_ASCAN_DIV: state_in = rem_rsp.busy ? afa_pkg::S_ASCAN_DIV
                                                       : afa_pkg::S_ASCAN_CK;
         afa_pkg::S_ASCAN_CK: begin
            priority if (!fits_c) begin
               state_in = afa_pkg::S_ASCAN_RD;
            end else if (alloc_fail_c) begin
               state_in = afa_pkg::S_DONE;
            end else begin
               state_in = afa_pkg::S_AEDIT;
            end
         end
         afa_pkg::S_AEDIT: begin
            unique case (aadds_c)
               2'd0:    state_in = afa_pkg::S_SD_RD;
               2'd2:    state_in = afa_pkg::S_SU_RD;
               default: state_in = afa_pkg::S_ANEXT;
            endcase
         end
         afa_pkg::S_ANEXT: state_in = (op_ff == afa_pkg::OP_ALLOC) ? afa_pkg::S_DONE
                                                                 : afa_pkg::S_FSCAN_RD;
         afa_pkg::S_SU_RD: state_in = (sh_ff == tgt_ff) ? afa_pkg::S_INSW : afa_pkg::S_SU_WR;
         afa_pkg::S_SU_WR: state_in = afa_pkg::S_SU_RD;
         afa_pkg::S_INSW:  state_in = ret_ff;
         afa_pkg::S_SD_RD: state_in = ((sh_ff + 1'b1) >= fcnt_ff) ? ret_ff
                                                                  : afa_pkg::S_SD_WR;
         afa_pkg::S_SD_WR: state_in = afa_pkg::S_SD_RD;
         afa_pkg::S_DONE:  state_in = (!rsp_valid_ff || !rsp_stall) ? afa_pkg::S_IDLE
                                                                   : afa_pkg::S_DONE;
         default: state_in = afa_pkg::S_IDLE;
      endcase
   end

   // datapath, table ports and result registers
   always_comb begin
      ret_in = ret_ff;  op_in = op_ff;  sts_in = sts_ff;  pool_in = pool_ff;
      roff_in = roff_ff;  rsize_in = rsize_ff;  ralign_in = ralign_ff;
      fcnt_in = fcnt_ff;  ucnt_in = ucnt_ff;  idx_in = idx_ff;  u_in = u_ff;
      ulen_in = ulen_ff;  p_in = p_ff;  mp_in = mp_ff;  mn_in = mn_ff;
      moving_in = moving_ff;  prevoff_in = prevoff_ff;  prevlen_in = prevlen_ff;
      nextlen_in = nextlen_ff;  aoff_in = aoff_ff;  alen_in = alen_ff;
      atrail_in = atrail_ff;  apad_in = apad_ff;  ai_in = ai_ff;
      sh_in = sh_ff;  tgt_in = tgt_ff;  ins_in = ins_ff;  res_in = res_ff;  mvd_in = mvd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;  rsp_off_in = rsp_off_ff;
      rsp_from_in = rsp_from_ff;  rsp_len_in = rsp_len_ff;  rsp_moved_in = rsp_moved_ff;
      f_we = 1'b0;  f_wa = '0;  f_wd = '0;  f_ra = idx_ff[afa_pkg::FIDX_W-1:0];
      u_we = 1'b0;  u_wa = '0;  u_wd = '0;  u_ra = idx_ff[afa_pkg::UIDX_W-1:0];
      rem_req.start    = 1'b0;
      rem_req.dividend = f_rd_ff.off;
      rem_req.divisor  = ralign_ff;

      unique case (state_ff)
         afa_pkg::S_INIT: begin
            // seed one free block covering the pool
            f_we = 1'b1;
            f_wd = '{off: '0, len: pool_ff};
            fcnt_in = FW'((pool_ff != '0));
            ucnt_in = '0;
         end
         afa_pkg::S_IDLE: begin
            if (csr_wr_en) begin
               pool_in = csr_wr_data;
            end else if (accept) begin
               op_in = afa_pkg::op_type'(req_op);
               roff_in = req_offset;  rsize_in = req_size;  ralign_in = req_align;
               idx_in = '0;  p_in = '0;  mp_in = 1'b0;  mn_in = 1'b0;  moving_in = 1'b0;
               sts_in = req_bad ? afa_pkg::STS_BAD : afa_pkg::STS_OK;
               res_in = '0;  mvd_in = 1'b0;
            end
         end
         afa_pkg::S_USCAN_RD: begin
            if (UW'(idx_ff) >= ucnt_ff) begin
               sts_in = afa_pkg::STS_NOT_FND;
            end
         end
         afa_pkg::S_USCAN_CK: begin
            if (u_rd_ff.off == roff_ff) begin
               u_in = idx_ff[afa_pkg::UIDX_W-1:0];
               ulen_in = u_rd_ff.len;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         afa_pkg::S_FSCAN_CK: begin
            // track the last block below the base and the block starting at base + length
            if (f_rd_ff.off < roff_ff) begin
               p_in = FW'(idx_ff) + 1'b1;
               mp_in = ({1'b0, f_rd_ff.off} + {1'b0, f_rd_ff.len}) == {1'b0, roff_ff};
               prevoff_in = f_rd_ff.off;
               prevlen_in = f_rd_ff.len;
            end else if ({1'b0, f_rd_ff.off} == ({1'b0, roff_ff} + {1'b0, ulen_ff})) begin
               mn_in = 1'b1;
               nextlen_in = f_rd_ff.len;
            end
            idx_in = idx_ff + 1'b1;
         end
         afa_pkg::S_FDECIDE: begin
            priority if (moving_ff) begin
               ret_in = afa_pkg::S_DONE;
            end else if (op_ff == afa_pkg::OP_FREE) begin
               if (free_full_c) begin
                  sts_in = afa_pkg::STS_FULL;
               end
            end else if (shrink_c) begin
               sts_in = afa_pkg::STS_BAD;
            end else if (same_c || grow_c) begin
               res_in = roff_ff;
            end else if (ralign_ff == '0) begin
               sts_in = afa_pkg::STS_BAD;
            end else begin
               idx_in = '0;
            end
         end
         afa_pkg::S_UMV_RD: begin
            u_ra = afa_pkg::UIDX_W'(ucnt_ff - 1'b1);
         end
         afa_pkg::S_UMV_WR: begin
            // move the last used entry into the hole
            u_we = 1'b1;  u_wa = u_ff;  u_wd = u_rd_ff;
            ucnt_in = ucnt_ff - 1'b1;
         end
         afa_pkg::S_FEDIT: begin
            ret_in = afa_pkg::S_DONE;
            priority if (mp_ff && mn_ff) begin
               f_we = 1'b1;
               f_wa = afa_pkg::FIDX_W'(p_ff - 1'b1);
               f_wd = '{off: prevoff_ff, len: prevlen_ff + ulen_ff + nextlen_ff};
               sh_in = p_ff;
            end else if (mp_ff) begin
               f_we = 1'b1;
               f_wa = afa_pkg::FIDX_W'(p_ff - 1'b1);
               f_wd = '{off: prevoff_ff, len: prevlen_ff + ulen_ff};
            end else if (mn_ff) begin
               f_we = 1'b1;
               f_wa = p_ff[afa_pkg::FIDX_W-1:0];
               f_wd = '{off: roff_ff, len: ulen_ff + nextlen_ff};
            end else begin
               sh_in = fcnt_ff;  tgt_in = p_ff;
               ins_in = '{off: roff_ff, len: ulen_ff};
            end
         end
         afa_pkg::S_GROW: begin
            // extend in place into the following free block
            u_we = 1'b1;  u_wa = u_ff;
            u_wd = '{off: roff_ff, len: rsize_ff};
            ret_in = afa_pkg::S_DONE;
            if (amt_c == nextlen_ff) begin
               sh_in = p_ff;
            end else begin
               f_we = 1'b1;
               f_wa = p_ff[afa_pkg::FIDX_W-1:0];
               f_wd = '{off: roff_ff + rsize_ff, len: nextlen_ff - amt_c};
            end
         end
         afa_pkg::S_ASCAN_RD: begin
            if (FW'(idx_ff) >= fcnt_ff) begin
               sts_in = afa_pkg::STS_NO_SPACE;
               res_in = '0;
            end
         end
         afa_pkg::S_ASCAN_LD: begin
            aoff_in = f_rd_ff.off;
            alen_in = f_rd_ff.len;
            rem_req.start = 1'b1;
         end
         afa_pkg::S_ASCAN_CK: begin
            priority if (!fits_c) begin
               idx_in = idx_ff + 1'b1;
            end else if (alloc_fail_c) begin
               sts_in = afa_pkg::STS_FULL;
               res_in = '0;
            end else begin
               ai_in = idx_ff[afa_pkg::FIDX_W-1:0];
               apad_in = pad_c;
               atrail_in = trail_c;
            end
         end
         afa_pkg::S_AEDIT: begin
            // record the new block, then split the chosen free block
            u_we = 1'b1;
            u_wd = '{off: newoff_c, len: rsize_ff};
            res_in = newoff_c;
            if (op_ff == afa_pkg::OP_ALLOC) begin
               u_wa = ucnt_ff[afa_pkg::UIDX_W-1:0];
               ucnt_in = ucnt_ff + 1'b1;
            end else begin
               u_wa = u_ff;
               mvd_in = 1'b1;
            end
            ret_in = afa_pkg::S_ANEXT;
            unique case (aadds_c)
               2'd0: sh_in = FW'(ai_ff);
               2'd2: begin
                  f_we = 1'b1;  f_wa = ai_ff;
                  f_wd = '{off: aoff_ff, len: AW'(apad_ff)};
                  sh_in = fcnt_ff;  tgt_in = FW'(ai_ff) + 1'b1;
                  ins_in = '{off: tailoff_c, len: atrail_ff};
               end
               default: begin
                  f_we = 1'b1;  f_wa = ai_ff;
                  f_wd = (apad_ff != '0) ? '{off: aoff_ff, len: AW'(apad_ff)}
                                         : '{off: tailoff_c, len: atrail_ff};
               end
            endcase
         end
         afa_pkg::S_ANEXT: begin
            // a moving realloc goes on to free the old block
            moving_in = 1'b1;
            idx_in = '0;  p_in = '0;  mp_in = 1'b0;  mn_in = 1'b0;
         end
         afa_pkg::S_SU_RD: begin
            f_ra = afa_pkg::FIDX_W'(sh_ff - 1'b1);
         end
         afa_pkg::S_SU_WR: begin
            f_we = 1'b1;  f_wa = sh_ff[afa_pkg::FIDX_W-1:0];  f_wd = f_rd_ff;
            sh_in = sh_ff - 1'b1;
         end
         afa_pkg::S_INSW: begin
            f_we = 1'b1;  f_wa = tgt_ff[afa_pkg::FIDX_W-1:0];  f_wd = ins_ff;
            fcnt_in = fcnt_ff + 1'b1;
         end
         afa_pkg::S_SD_RD: begin
            f_ra = afa_pkg::FIDX_W'(sh_ff + 1'b1);
            if ((sh_ff + 1'b1) >= fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1;
            end
         end
         afa_pkg::S_SD_WR: begin
            f_we = 1'b1;  f_wa = sh_ff[afa_pkg::FIDX_W-1:0];  f_wd = f_rd_ff;
            sh_in = sh_ff + 1'b1;
         end
         afa_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sts_ff;
               rsp_off_in    = res_ff;
               rsp_moved_in  = mvd_ff;
               rsp_from_in   = mvd_ff ? roff_ff : '0;
               rsp_len_in    = mvd_ff ? ulen_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // table storage with registered reads
   always_ff @(posedge clock) begin
      if (f_we) begin
         fmem[f_wa] <= f_wd;
      end
      f_rd_ff <= fmem[f_ra];
   end

   always_ff @(posedge clock) begin
      if (u_we) begin
         umem[u_wa] <= u_wd;
      end
      u_rd_ff <= umem[u_ra];
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afa_pkg::S_INIT;
         pool_ff      <= afa_pkg::POOL_RESET;
         rsp_valid_ff <= 1'b0;
         fcnt_ff      <= '0;
         ucnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
         fcnt_ff      <= fcnt_in;
         ucnt_ff      <= ucnt_in;
      end
      ret_ff <= ret_in;  op_ff <= op_in;  sts_ff <= sts_in;
      roff_ff <= roff_in;  rsize_ff <= rsize_in;  ralign_ff <= ralign_in;
      idx_ff <= idx_in;  u_ff <= u_in;  ulen_ff <= ulen_in;
      p_ff <= p_in;  mp_ff <= mp_in;  mn_ff <= mn_in;  moving_ff <= moving_in;
      prevoff_ff <= prevoff_in;  prevlen_ff <= prevlen_in;  nextlen_ff <= nextlen_in;
      aoff_ff <= aoff_in;  alen_ff <= alen_in;  atrail_ff <= atrail_in;
      apad_ff <= apad_in;  ai_ff <= ai_in;
      sh_ff <= sh_in;  tgt_ff <= tgt_in;  ins_ff <= ins_in;
      res_ff <= res_in;  mvd_ff <= mvd_in;
      rsp_status_ff <= rsp_status_in;  rsp_off_ff <= rsp_off_in;
      rsp_from_ff <= rsp_from_in;  rsp_len_ff <= rsp_len_in;  rsp_moved_ff <= rsp_moved_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_offset  = rsp_off_ff;
   assign rsp_moved       = rsp_moved_ff;
   assign rsp_copy_from   = rsp_from_ff;
   assign rsp_copy_length = rsp_len_ff;

endmodule
